[rtl/ecma_pkg.sv]
// Package: payload types, sequencer states and fixed widths for the moving average unit
package ecma_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int HW_BITS = 3;
    localparam logic [HW_BITS-1:0] HW_RESET = 3'd3;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          end_of_stream;
    } sample_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] mean;
        logic                          final_mean;
    } result_t;

    typedef enum logic {
        ST_IDLE,
        ST_FLUSH
    } seq_state_t;

endpackage

[rtl/ecma_cell.sv]
// Delay line cell: one sample register that takes its neighbor's value on a shift
module ecma_cell
    import ecma_pkg::*;
(
    input  logic                          clk,
    input  logic                          shift_en,
    input  logic signed [SAMPLE_BITS-1:0] d,
    output logic signed [SAMPLE_BITS-1:0] q
);

    logic signed [SAMPLE_BITS-1:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            q_reg <= d;
        end
    end

    assign q = q_reg;

endmodule

[rtl/ecma_div.sv]
// Signed sum by small count divider: reciprocal multiply, one-step correction, output register
module ecma_div
    import ecma_pkg::*;
#(
    parameter int SUMW = 28,
    parameter int CNTW = 4
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    input  logic signed [SUMW-1:0] req_sum,
    input  logic [CNTW-1:0]        req_cnt,
    input  logic                   req_fin,
    output logic                   ready,
    output logic                   result_valid,
    input  logic                   result_stall,
    output result_t                result_item
);

    localparam int K = SUMW;
    localparam int RW = K + 1;
    localparam int NCNT = 1 << CNTW;

    logic [RW-1:0] recip_tab [NCNT];

    for (genvar d = 0; d < NCNT; d++)
    begin : g_recip
        localparam logic [RW-1:0] RV =
            (d == 0) ? '0 : RW'((64'd1 << K) / ((d == 0) ? 1 : d));
        assign recip_tab[d] = RV;
    end

    logic            adv;
    logic            s1_valid_reg;
    logic [SUMW-1:0] s1_mag_reg;
    logic            s1_neg_reg;
    logic [CNTW-1:0] s1_cnt_reg;
    logic            s1_fin_reg;
    logic [RW-1:0]   s1_recip_reg;
    logic            s2_valid_reg;
    logic [SUMW-1:0] s2_q_reg;
    logic [SUMW-1:0] s2_mag_reg;
    logic            s2_neg_reg;
    logic [CNTW-1:0] s2_cnt_reg;
    logic            s2_fin_reg;
    logic            out_valid_reg;
    result_t         out_reg;

    logic [SUMW-1:0]      req_mag;
    logic [SUMW+RW-1:0]   prod;
    logic [SUMW+CNTW-1:0] qd;
    logic [SUMW+CNTW-1:0] rem;
    logic [SUMW-1:0]      q_fix;
    logic [SUMW-1:0]      q_signed;

    assign adv = !out_valid_reg || !result_stall;
    assign ready = adv;

    assign req_mag = req_sum[SUMW-1] ? SUMW'(-req_sum) : SUMW'(req_sum);
    assign prod = (SUMW+RW)'(s1_mag_reg) * (SUMW+RW)'(s1_recip_reg);
    assign qd = (SUMW+CNTW)'(s2_q_reg) * (SUMW+CNTW)'(s2_cnt_reg);
    assign rem = (SUMW+CNTW)'(s2_mag_reg) - qd;
    assign q_fix = (rem >= (SUMW+CNTW)'(s2_cnt_reg)) ? s2_q_reg + 1'b1 : s2_q_reg;
    assign q_signed = s2_neg_reg ? -q_fix : q_fix;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= req_valid;
            s2_valid_reg <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_mag_reg <= req_mag;
            s1_neg_reg <= req_sum[SUMW-1];
            s1_cnt_reg <= req_cnt;
            s1_fin_reg <= req_fin;
            s1_recip_reg <= recip_tab[req_cnt];
            s2_q_reg <= prod[K +: SUMW];
            s2_mag_reg <= s1_mag_reg;
            s2_neg_reg <= s1_neg_reg;
            s2_cnt_reg <= s1_cnt_reg;
            s2_fin_reg <= s1_fin_reg;
            out_reg.mean <= q_signed[SAMPLE_BITS-1:0];
            out_reg.final_mean <= s2_fin_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_item = out_reg;

endmodule

[rtl/edge_clipped_moving_average_unit.sv]
// Top level: edge-clipped centered moving average over a chain of delay cells
// A result passes the divider's s1 and s2 registers and then its output register.
// Throughput: one sample per cycle while sample_stall is low; the divider pipeline stalls as a whole on result_stall.
// A sample marked end_of_stream starts a flush (walk down the delay line, issuing the
// pending results as the window shrinks) during which no sample is taken.
// Reset: half_width = 3, stream empty, no result pending.
module edge_clipped_moving_average_unit
    import ecma_pkg::*;
#(
    parameter int MAX_HALF_WIDTH = 7
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    output logic               sample_stall,
    input  sample_t            sample_item,
    output logic               result_valid,
    input  logic               result_stall,
    output result_t            result_item,
    input  logic               cfg_write,
    input  logic [HW_BITS-1:0] cfg_data
);

    localparam int LINE_DEPTH = 2 * MAX_HALF_WIDTH + 1;
    localparam int IDXW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CNTW = $clog2(LINE_DEPTH + 1);
    localparam int SUMW = SAMPLE_BITS + CNTW;
    localparam logic [7:0] MAXH8 = 8'(MAX_HALF_WIDTH);
    localparam logic [CNTW-1:0] DEPTH_C = CNTW'(LINE_DEPTH);

    logic [HW_BITS-1:0]   hw_reg;
    seq_state_t           state_reg, state_next;
    logic [CNTW-1:0]      seen_reg, seen_next;
    logic [CNTW-1:0]      pend_reg, pend_next;
    logic signed [SUMW-1:0] sum_reg, sum_next;
    logic [IDXW-1:0]      t0_reg, t0_next;
    logic [IDXW-1:0]      t_reg, t_next;
    logic [CNTW-1:0]      j_reg, j_next;

    logic signed [SAMPLE_BITS-1:0] tap [LINE_DEPTH];
    logic signed [SAMPLE_BITS-1:0] tap_rd;
    logic [IDXW-1:0]      rd_idx;
    logic                 shift_en;

    logic [7:0]           h8, size8, topj8, t0_8;
    logic [CNTW-1:0]      h_c, size_c, seen_inc, cnt_norm;
    logic signed [SUMW-1:0] sub_val, new_sum;
    logic                 accept, last, flushing, hit, flush_done;

    logic                 div_ready, req_valid, req_fin;
    logic signed [SUMW-1:0] req_sum;
    logic [CNTW-1:0]      req_cnt;

    // delay line
    for (genvar i = 0; i < LINE_DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            ecma_cell u_cell (
                .clk      (clk),
                .shift_en (shift_en),
                .d        (sample_item.sample),
                .q        (tap[i])
            );
        end
        else
        begin : g_body
            ecma_cell u_cell (
                .clk      (clk),
                .shift_en (shift_en),
                .d        (tap[i-1]),
                .q        (tap[i])
            );
        end
    end

    assign h8 = (8'(hw_reg) > MAXH8) ? MAXH8 : 8'(hw_reg);
    assign size8 = (h8 << 1) + 8'd1;
    assign h_c = CNTW'(h8);
    assign size_c = CNTW'(size8);

    assign flushing = (state_reg == ST_FLUSH);
    assign last = sample_item.end_of_stream;
    assign sample_stall = !((state_reg == ST_IDLE) && div_ready);
    assign accept = (state_reg == ST_IDLE) && sample_valid && !sample_stall;

    assign rd_idx = flushing ? t0_reg : IDXW'(size8 - 8'd1);
    assign tap_rd = tap[rd_idx];

    assign seen_inc = (seen_reg < DEPTH_C) ? seen_reg + 1'b1 : seen_reg;
    assign cnt_norm = (seen_inc < size_c) ? seen_inc : size_c;
    assign sub_val = (seen_reg >= size_c) ? SUMW'(tap_rd) : '0;
    assign new_sum = sum_reg - sub_val + SUMW'(sample_item.sample);
    assign t0_8 = ((size8 - 8'd1) < (8'(seen_inc) - 8'd1)) ?
                  (size8 - 8'd1) : (8'(seen_inc) - 8'd1);

    // window top of the flush output at distance j from the newest sample
    assign topj8 = ((8'(j_reg) + h8) < (8'(seen_reg) - 8'd1)) ?
                   (8'(j_reg) + h8) : (8'(seen_reg) - 8'd1);
    assign hit = flushing && (topj8 == 8'(t_reg));
    assign flush_done = hit && div_ready && (j_reg == '0);

    assign shift_en = accept || (flushing && !hit);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (flush_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        seen_next = seen_reg;
        pend_next = pend_reg;
        sum_next = sum_reg;
        t0_next = t0_reg;
        t_next = t_reg;
        j_next = j_reg;
        req_valid = 1'b0;
        req_sum = new_sum;
        req_cnt = cnt_norm;
        req_fin = 1'b0;
        if (cfg_write)
        begin
            seen_next = '0;
            pend_next = '0;
            sum_next = '0;
        end
        else if (accept)
        begin
            if (last)
            begin
                seen_next = seen_inc;
                sum_next = new_sum;
                t0_next = IDXW'(t0_8);
                t_next = IDXW'(t0_8);
                j_next = pend_reg;
            end
            else
            begin
                seen_next = seen_inc;
                sum_next = new_sum;
                if (pend_reg >= h_c)
                begin
                    req_valid = 1'b1;
                    pend_next = h_c;
                end
                else
                begin
                    pend_next = pend_reg + 1'b1;
                end
            end
        end
        else if (flushing)
        begin
            req_sum = sum_reg;
            req_cnt = CNTW'(t_reg) + 1'b1;
            req_fin = (j_reg == '0);
            if (hit)
            begin
                req_valid = 1'b1;
                if (flush_done)
                begin
                    seen_next = '0;
                    pend_next = '0;
                    sum_next = '0;
                end
                else if (div_ready)
                begin
                    j_next = j_reg - 1'b1;
                end
            end
            else
            begin
                sum_next = sum_reg - SUMW'(tap_rd);
                t_next = t_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hw_reg <= HW_RESET;
            state_reg <= ST_IDLE;
            seen_reg <= '0;
            pend_reg <= '0;
            sum_reg <= '0;
            t0_reg <= '0;
            t_reg <= '0;
            j_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                hw_reg <= cfg_data;
            end
            state_reg <= state_next;
            seen_reg <= seen_next;
            pend_reg <= pend_next;
            sum_reg <= sum_next;
            t0_reg <= t0_next;
            t_reg <= t_next;
            j_reg <= j_next;
        end
    end

    ecma_div #(
        .SUMW (SUMW),
        .CNTW (CNTW)
    ) u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_sum      (req_sum),
        .req_cnt      (req_cnt),
        .req_fin      (req_fin),
        .ready        (div_ready),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

endmodule
